### design/stl_pkg.sv
// Shared types and constants for the slot table with linked order.
package stl_pkg;

	localparam int SLOT_W  = 8;
	localparam int WORD_W  = 32;
	localparam int WBIT_W  = 5;
	localparam int WIDX_W  = SLOT_W - WBIT_W;

	localparam logic [1:0] MODE_ALLOC   = 2'd0;
	localparam logic [1:0] MODE_RELEASE = 2'd1;
	localparam logic [1:0] MODE_LINK    = 2'd2;
	localparam logic [1:0] MODE_UNLINK  = 2'd3;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NO_FREE = 2'd1;
	localparam logic [1:0] STAT_RANGE   = 2'd2;

	localparam logic [SLOT_W-1:0] LINK_NONE = 8'hFE;
	localparam logic [SLOT_W-1:0] LINK_END  = 8'hFF;

	typedef struct packed {
		logic [1:0]        mode;
		logic [SLOT_W-1:0] slot;
		logic [SLOT_W-1:0] range_high;
	} cmd_beat_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [SLOT_W-1:0] slot_out;
		logic [SLOT_W-1:0] head_out;
	} rsp_beat_t;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] slot;
	} find_res_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_UWR1,
		S_UWR2,
		S_RESP
	} state_t;

endpackage

### design/slot_table_with_linked_order.sv
// Top level: first-fit slot allocator with a doubly linked slot list.
//
//  channel | dir | beat type  | handshake
//  --------+-----+------------+------------------------
//  cmd     | in  | cmd_beat_t | cmd_valid / cmd_ready
//  rsp     | out | rsp_beat_t | rsp_valid / rsp_ready
//
// One command in flight. Release and link are done in S_EXEC, unlink does
// one link-memory read and then two write states (S_UWR1, S_UWR2), and
// allocate scans the 32-slot occupied words in turn, up to
// ceil(NUM_SLOTS/32) of them. The occupied-word scan sets the allocate time.
// After reset a clearing pass over all NUM_SLOTS entries fills both link
// memories with the unlinked mark; cmd_ready stays low meanwhile.
// A held response does not block accepting the next command; that command
// waits in its final state until the response register frees up.
module slot_table_with_linked_order import stl_pkg::*; #(
	parameter int NUM_SLOTS = 224
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_beat_t cmd,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_beat_t rsp
);

	localparam int NUM_WORDS = (NUM_SLOTS + WORD_W - 1) / WORD_W;
	localparam int WW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int IW        = $clog2(NUM_SLOTS);
	localparam logic [SLOT_W-1:0] SLOT_LIM  = SLOT_W'(NUM_SLOTS);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
	localparam logic [IW-1:0]     LAST_IDX  = IW'(NUM_SLOTS - 1);

	// ---------------------------------------------------------------
	// State
	// ---------------------------------------------------------------
	state_t            state_q, state_d;
	cmd_beat_t         cmd_q;
	rsp_beat_t         rsp_q;
	logic              rsp_valid_q;
	logic [1:0]        status_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic [SLOT_W-1:0] head_q;
	logic [WW-1:0]     w_q;          // occupied word under scan
	logic [IW-1:0]     clr_q;        // clearing pass pointer

	logic [WORD_W-1:0] occ_q [NUM_WORDS];

	// link memories, one write and one read port each, registered read
	logic [SLOT_W-1:0] next_mem [NUM_SLOTS];
	logic [SLOT_W-1:0] prev_mem [NUM_SLOTS];
	logic [SLOT_W-1:0] nx_rd_q, pv_rd_q;

	// ---------------------------------------------------------------
	// Decode of the held command
	// ---------------------------------------------------------------
	logic              slot_bad;
	logic [SLOT_W-1:0] hi_c;
	logic [WIDX_W-1:0] hi_word;
	logic [WIDX_W-1:0] w_ext;
	logic              rsp_free;
	logic [IW-1:0]     s_idx;
	find_res_t         fr;

	assign slot_bad = cmd_q.slot >= SLOT_LIM;
	assign hi_c     = (cmd_q.range_high > LAST_SLOT) ? LAST_SLOT : cmd_q.range_high;
	assign hi_word  = hi_c[SLOT_W-1:WBIT_W];
	assign w_ext    = WIDX_W'(w_q);
	assign rsp_free = !rsp_valid_q || rsp_ready;
	assign s_idx    = cmd_q.slot[IW-1:0];

	stl_find_free u_find (
		.occ_word (occ_q[w_q]),
		.word_idx (w_ext),
		.lo       (cmd_q.slot),
		.hi       (hi_c),
		.res      (fr)
	);

	// ---------------------------------------------------------------
	// Next state
	// ---------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (clr_q == LAST_IDX) state_d = S_IDLE;
			S_IDLE:  if (cmd_valid) state_d = S_EXEC;
			S_EXEC: begin
				if (slot_bad) begin
					state_d = S_RESP;
				end else begin
					unique case (cmd_q.mode)
						MODE_ALLOC:   state_d = (cmd_q.slot > hi_c) ? S_RESP : S_SCAN;
						MODE_UNLINK:  state_d = S_UWR1;
						default:      state_d = S_RESP;
					endcase
				end
			end
			S_SCAN:  if (fr.found || w_ext == hi_word) state_d = S_RESP;
			S_UWR1:  state_d = S_UWR2;
			S_UWR2:  state_d = S_RESP;
			S_RESP:  if (rsp_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// ---------------------------------------------------------------
	// Actions per state
	// ---------------------------------------------------------------
	logic              nx_we, pv_we, occ_we, occ_wval, head_we, res_we;
	logic              w_load, w_inc;
	logic [IW-1:0]     nx_waddr, pv_waddr;
	logic [SLOT_W-1:0] nx_wdata, pv_wdata, occ_addr, head_wval;
	logic [1:0]        res_status;
	logic [SLOT_W-1:0] res_slot;

	always_comb begin
		nx_we      = 1'b0;
		nx_waddr   = s_idx;
		nx_wdata   = LINK_NONE;
		pv_we      = 1'b0;
		pv_waddr   = s_idx;
		pv_wdata   = LINK_NONE;
		occ_we     = 1'b0;
		occ_addr   = cmd_q.slot;
		occ_wval   = 1'b0;
		head_we    = 1'b0;
		head_wval  = cmd_q.slot;
		res_we     = 1'b0;
		res_status = STAT_OK;
		res_slot   = cmd_q.slot;
		w_load     = 1'b0;
		w_inc      = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				nx_we    = 1'b1;
				pv_we    = 1'b1;
				nx_waddr = clr_q;
				pv_waddr = clr_q;
			end
			S_EXEC: begin
				if (slot_bad) begin
					res_we     = 1'b1;
					res_status = STAT_RANGE;
				end else begin
					unique case (cmd_q.mode)
						MODE_ALLOC: begin
							if (cmd_q.slot > hi_c) begin
								res_we     = 1'b1;
								res_status = STAT_NO_FREE;
							end else begin
								w_load = 1'b1;
							end
						end
						MODE_RELEASE: begin
							occ_we   = 1'b1;
							nx_we    = 1'b1;
							pv_we    = 1'b1;
							nx_wdata = '0;
							pv_wdata = '0;
							res_we   = 1'b1;
						end
						MODE_LINK: begin
							nx_we    = 1'b1;
							nx_wdata = head_q;
							// old head gets a back link unless the list was empty
							if (head_q < SLOT_LIM) begin
								pv_we    = 1'b1;
								pv_waddr = head_q[IW-1:0];
								pv_wdata = cmd_q.slot;
							end
							head_we = 1'b1;
							res_we  = 1'b1;
						end
						MODE_UNLINK: begin
							// link read of the slot is in flight this cycle
						end
						default: ;
					endcase
				end
			end
			S_SCAN: begin
				if (fr.found) begin
					occ_we   = 1'b1;
					occ_addr = fr.slot;
					occ_wval = 1'b1;
					nx_we    = 1'b1;
					pv_we    = 1'b1;
					nx_waddr = fr.slot[IW-1:0];
					pv_waddr = fr.slot[IW-1:0];
					res_we   = 1'b1;
					res_slot = fr.slot;
				end else if (w_ext == hi_word) begin
					res_we     = 1'b1;
					res_status = STAT_NO_FREE;
				end else begin
					w_inc = 1'b1;
				end
			end
			S_UWR1: begin
				if (cmd_q.slot == head_q) begin
					head_we   = 1'b1;
					head_wval = nx_rd_q;
				end else begin
					// neighbors bypass the slot; stale or end marks are dropped
					if (pv_rd_q < SLOT_LIM) begin
						nx_we    = 1'b1;
						nx_waddr = pv_rd_q[IW-1:0];
						nx_wdata = nx_rd_q;
					end
					if (nx_rd_q < SLOT_LIM) begin
						pv_we    = 1'b1;
						pv_waddr = nx_rd_q[IW-1:0];
						pv_wdata = pv_rd_q;
					end
				end
				res_we = 1'b1;
			end
			S_UWR2: begin
				// own links last, so they win over a self link
				nx_we = 1'b1;
				pv_we = 1'b1;
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------
	// Control registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			head_q      <= LINK_END;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < NUM_WORDS; i++) begin
				occ_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (head_we) begin
				head_q <= head_wval;
			end
			if (occ_we) begin
				occ_q[occ_addr[WBIT_W +: WW]][occ_addr[WBIT_W-1:0]] <= occ_wval;
			end
			if (state_q == S_RESP && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_q <= cmd;
		end
		if (w_load) begin
			w_q <= cmd_q.slot[WBIT_W +: WW];
		end else if (w_inc) begin
			w_q <= w_q + 1'b1;
		end
		if (res_we) begin
			status_q   <= res_status;
			res_slot_q <= res_slot;
		end
		if (state_q == S_RESP && rsp_free) begin
			rsp_q.status   <= status_q;
			rsp_q.slot_out <= res_slot_q;
			rsp_q.head_out <= head_q;
		end
	end

	// link memories
	always_ff @(posedge clk) begin
		nx_rd_q <= next_mem[s_idx];
		pv_rd_q <= prev_mem[s_idx];
		if (nx_we) begin
			next_mem[nx_waddr] <= nx_wdata;
		end
		if (pv_we) begin
			prev_mem[pv_waddr] <= pv_wdata;
		end
	end

	assign cmd_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
`ifndef ASSERT_OFF
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("second command taken while one is in flight");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> w_ext <= hi_word)
		else $error("occupied scan ran past the top of the range");

	a_alloc_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN && fr.found |-> fr.slot >= cmd_q.slot && fr.slot <= hi_c)
		else $error("allocated slot outside the requested range");
`endif

endmodule

### design/stl_find_free.sv
// First free slot within an index window over one word of occupied bits.
module stl_find_free import stl_pkg::*; (
	input  logic [WORD_W-1:0] occ_word,
	input  logic [WIDX_W-1:0] word_idx,
	input  logic [SLOT_W-1:0] lo,
	input  logic [SLOT_W-1:0] hi,
	output find_res_t         res
);

	always_comb begin
		logic [SLOT_W-1:0] idx;
		res = '0;
		// descending, so the lowest hit is the one left standing
		for (int b = WORD_W - 1; b >= 0; b--) begin
			idx = {word_idx, WBIT_W'(b)};
			if (!occ_word[b] && idx >= lo && idx <= hi) begin
				res.found = 1'b1;
				res.slot  = idx;
			end
		end
	end

endmodule

### tb/slot_table_checker.sv
// Checker for the slot table: watches both channels, predicts responses, compares them.
`timescale 1ns / 1ps

module slot_table_checker import stl_pkg::*; #(
	parameter int NUM_SLOTS = 224
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  logic      cmd_ready,
	input  cmd_beat_t cmd,
	input  logic      rsp_valid,
	input  logic      rsp_ready,
	input  rsp_beat_t rsp,
	output int        fail_count,
	output int        pending
);

	// Predicted table contents
	logic              slot_busy [NUM_SLOTS];
	logic [SLOT_W-1:0] link_next [NUM_SLOTS];
	logic [SLOT_W-1:0] link_prev [NUM_SLOTS];
	logic [SLOT_W-1:0] list_head;

	rsp_beat_t expected_rsp[$];
	int        fail_total;

	// Applies one command to the predicted table and returns its response.
	function automatic rsp_beat_t apply_command(input cmd_beat_t c);
		rsp_beat_t         r;
		logic [SLOT_W-1:0] top_idx;
		logic [SLOT_W-1:0] nx;
		logic [SLOT_W-1:0] pv;
		logic [SLOT_W-1:0] old_head;
		logic              found;
		int                i;
		r.status   = STAT_OK;
		r.slot_out = c.slot;
		if (c.slot >= NUM_SLOTS) begin
			r.status = STAT_RANGE;
		end else begin
			case (c.mode)
				MODE_ALLOC: begin
					top_idx = (c.range_high > NUM_SLOTS - 1) ?
						SLOT_W'(NUM_SLOTS - 1) : c.range_high;
					found = 1'b0;
					for (i = c.slot; i <= top_idx && !found; i++) begin
						if (!slot_busy[i]) begin
							slot_busy[i] = 1'b1;
							link_next[i] = LINK_NONE;
							link_prev[i] = LINK_NONE;
							r.slot_out   = SLOT_W'(i);
							found        = 1'b1;
						end
					end
					if (!found)
						r.status = STAT_NO_FREE;
				end
				MODE_RELEASE: begin
					slot_busy[c.slot] = 1'b0;
					link_next[c.slot] = '0;
					link_prev[c.slot] = '0;
				end
				MODE_LINK: begin
					old_head          = list_head;
					link_next[c.slot] = old_head;
					list_head         = c.slot;
					if (old_head != LINK_END && old_head < NUM_SLOTS)
						link_prev[old_head] = c.slot;
				end
				MODE_UNLINK: begin
					nx = link_next[c.slot];
					pv = link_prev[c.slot];
					if (c.slot == list_head) begin
						list_head = nx;
					end else begin
						// writes aimed past the table are dropped
						if (pv < NUM_SLOTS)
							link_next[pv] = nx;
						if (nx != LINK_END && nx < NUM_SLOTS)
							link_prev[nx] = pv;
					end
					link_next[c.slot] = LINK_NONE;
					link_prev[c.slot] = LINK_NONE;
				end
			endcase
		end
		r.head_out = list_head;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_beat_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_busy[i] = 1'b0;
				link_next[i] = LINK_NONE;
				link_prev[i] = LINK_NONE;
			end
			list_head = LINK_END;
			expected_rsp.delete();
			fail_total = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			// response first: a beat taken in this cycle belongs to an older command
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp.size() == 0) begin
					$error("unexpected response beat: status %0d slot_out %0d head_out %0d",
						rsp.status, rsp.slot_out, rsp.head_out);
					fail_total++;
				end else begin
					want = expected_rsp.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						fail_total++;
					end
					if (rsp.slot_out !== want.slot_out) begin
						$error("slot_out: expected %0d, got %0d", want.slot_out, rsp.slot_out);
						fail_total++;
					end
					if (rsp.head_out !== want.head_out) begin
						$error("head_out: expected %0d, got %0d", want.head_out, rsp.head_out);
						fail_total++;
					end
				end
			end
			if (cmd_valid && cmd_ready)
				expected_rsp.push_back(apply_command(cmd));
			fail_count <= fail_total;
			pending    <= expected_rsp.size();
		end
	end

endmodule

### tb/tb_slot_table_with_linked_order.sv
// Testbench top for the slot table: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module tb_slot_table_with_linked_order;
	import stl_pkg::*;

	localparam int NUM_SLOTS        = 224;
	localparam int WIN_SIZE         = 16;
	localparam int RANDOM_PER_PHASE = 610;
	// No beat for this many cycles means the block is stuck. Covers the
	// post-reset clearing pass and long random stalls with wide margin.
	localparam int STALL_LIMIT      = 5000;
	// Slowest command is allocate: up to 7 occupied word scans, plus response hold.
	localparam int DRAIN_CYCLES     = 40;

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_ready;
	cmd_beat_t cmd;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_beat_t rsp;

	int fail_count;
	int pending;
	int stall_cycles = 0;

	// Idle percentages per side; changed between phases
	int tx_idle_pct;
	int rx_idle_pct;

	// Stimulus bookkeeping: slots this bench believes are on the list, and
	// the window of slots that random commands currently hammer on.
	logic [SLOT_W-1:0] linked_q[$];
	bit                in_list [0:255];
	int                win_base;

	slot_table_with_linked_order #(
		.NUM_SLOTS(NUM_SLOTS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	slot_table_checker #(
		.NUM_SLOTS(NUM_SLOTS)
	) checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Receiver: ready is redrawn every falling edge, so stalls land on any
	// cycle of the block's work, including while a response is held.
	always @(negedge clk) begin
		rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// Watchdog: counts cycles with no beat on either channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("CHECK FAILED");
					$finish;
				end
			end
		end
	end

	// Drives one command beat. Valid goes up at a falling edge and stays up
	// with the payload held until the beat is taken. A random idle stretch
	// may come first; valid is only lowered there, never in the same step
	// it is raised, so back-to-back beats keep valid high throughout.
	task automatic send_cmd(input cmd_beat_t c);
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
	endtask

	task automatic send_fields(input logic [1:0] m, input logic [SLOT_W-1:0] s,
		input logic [SLOT_W-1:0] h);
		cmd_beat_t c;
		c.mode       = m;
		c.slot       = s;
		c.range_high = h;
		send_cmd(c);
	endtask

	// Random command. Most are well formed within a small sliding window:
	// allocate over the window, link slots not yet on the list, unlink
	// slots that are on it, release slots that are not. The rest is noise
	// over the full field ranges and deliberately wrong list operations.
	task automatic next_random_cmd(output cmd_beat_t c);
		int roll;
		int tries;
		int pick;
		if ($urandom_range(0, 39) == 0) begin
			// the window may hang off the end so out-of-table slots show up
			if ($urandom_range(0, 3) == 0)
				win_base = 0;
			else
				win_base = $urandom_range(0, NUM_SLOTS - WIN_SIZE / 2);
		end
		roll         = $urandom_range(0, 99);
		c.mode       = MODE_ALLOC;
		c.slot       = SLOT_W'(win_base + $urandom_range(0, WIN_SIZE - 1));
		c.range_high = SLOT_W'($urandom_range(0, 255));
		if (roll < 8) begin
			c.mode = 2'($urandom_range(0, 3));
			c.slot = SLOT_W'($urandom_range(0, 255));
		end else if (roll < 38) begin
			// mostly a range inside the window; else full-range upper bound,
			// which gives clamped and reversed ranges
			if ($urandom_range(0, 9) != 0)
				c.range_high = SLOT_W'(win_base + $urandom_range(0, WIN_SIZE - 1));
		end else if (roll < 52) begin
			c.mode = MODE_RELEASE;
			for (tries = 0; tries < 4 && in_list[c.slot]; tries++)
				c.slot = SLOT_W'(win_base + $urandom_range(0, WIN_SIZE - 1));
		end else if (roll < 76) begin
			c.mode = MODE_LINK;
			for (tries = 0; tries < 4 && in_list[c.slot]; tries++)
				c.slot = SLOT_W'(win_base + $urandom_range(0, WIN_SIZE - 1));
			if (!in_list[c.slot]) begin
				in_list[c.slot] = 1'b1;
				linked_q.push_back(c.slot);
			end
		end else begin
			c.mode = MODE_UNLINK;
			if (linked_q.size() != 0 && $urandom_range(0, 9) != 0) begin
				pick            = $urandom_range(0, linked_q.size() - 1);
				c.slot          = linked_q[pick];
				linked_q.delete(pick);
				in_list[c.slot] = 1'b0;
			end
		end
	endtask

	initial begin
		cmd_beat_t c;
		arst_n       = 1'b0;
		cmd_valid    = 1'b0;
		cmd          = '0;
		tx_idle_pct  = 17;
		rx_idle_pct  = 84;
		win_base     = 0;
		for (int i = 0; i < 256; i++)
			in_list[i] = 1'b0;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part
		// allocate: single-slot range, clamped upper bound, last slot,
		// full range at the top, reversed range, index past the table
		send_fields(MODE_ALLOC, 8'd0, 8'd0);
		send_fields(MODE_ALLOC, 8'd0, 8'd255);
		send_fields(MODE_ALLOC, SLOT_W'(NUM_SLOTS - 1), 8'd255);
		send_fields(MODE_ALLOC, SLOT_W'(NUM_SLOTS - 1), SLOT_W'(NUM_SLOTS - 1));
		send_fields(MODE_ALLOC, 8'd10, 8'd5);
		send_fields(MODE_ALLOC, SLOT_W'(NUM_SLOTS), 8'd255);
		send_fields(MODE_ALLOC, 8'd255, 8'd255);
		// every other mode with a slot past the table
		send_fields(MODE_RELEASE, 8'd255, 8'd0);
		send_fields(MODE_LINK, SLOT_W'(NUM_SLOTS), 8'hAA);
		send_fields(MODE_UNLINK, 8'd254, 8'h55);
		// build a three-entry list, then unlink middle, head, last
		send_fields(MODE_LINK, 8'd0, 8'hFF);
		send_fields(MODE_LINK, 8'd1, 8'h00);
		send_fields(MODE_LINK, SLOT_W'(NUM_SLOTS - 1), 8'h0F);
		send_fields(MODE_UNLINK, 8'd1, 8'hF0);
		send_fields(MODE_UNLINK, SLOT_W'(NUM_SLOTS - 1), 8'd0);
		send_fields(MODE_UNLINK, 8'd0, 8'd0);
		// link a free slot; unlink a slot that was never linked, whose
		// link writes target marks outside the table and get dropped
		send_fields(MODE_LINK, 8'd5, 8'd0);
		send_fields(MODE_UNLINK, 8'd7, 8'd0);
		// release a slot that is still the list head, then unlink it:
		// its zeroed links now point at slot 0
		send_fields(MODE_RELEASE, 8'd5, 8'hAA);
		send_fields(MODE_UNLINK, 8'd5, 8'd0);
		send_fields(MODE_RELEASE, 8'd0, 8'd0);
		send_fields(MODE_RELEASE, SLOT_W'(NUM_SLOTS - 1), 8'd255);

		// Random part in three idle phases: slow receiver, slow sender, none
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 17;
					rx_idle_pct = 84;
				end
				1: begin
					tx_idle_pct = 84;
					rx_idle_pct = 17;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			repeat (RANDOM_PER_PHASE) begin
				next_random_cmd(c);
				send_cmd(c);
			end
		end

		@(negedge clk);
		cmd_valid <= 1'b0;

		// Drain: the watchdog bounds this wait
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
